@@ hdl/tcse_pkg.sv @@
// Shared types, constants and helpers for the text console scroll engine.
// No dependencies.
`timescale 1ns / 1ps
package tcse_pkg;
   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int SCREENS = 4;
   localparam int SCREEN_CELLS = COLUMNS * ROWS;
   localparam int STORE_CELLS = SCREEN_CELLS * SCREENS;
   localparam int ADDR_W = $clog2(STORE_CELLS);
   localparam int SCELL_W = $clog2(SCREEN_CELLS + 1);
   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int SCR_W = 2;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [15:0] BLANK_CELL = 16'h0700;

   typedef enum logic [2:0] {
      REQ_PRINT = 3'd0, REQ_WRITE = 3'd1, REQ_READ = 3'd2,
      REQ_CURSOR = 3'd3, REQ_CLEAR = 3'd4, REQ_COPY = 3'd5,
      REQ_NONE6 = 3'd6, REQ_NONE7 = 3'd7
   } req_code_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] char_code;
      logic [7:0] color_value;
      logic       write_code;
      logic       write_color;
      logic [6:0] pos_x;
      logic [4:0] pos_y;
      logic [1:0] copy_from;
      logic [1:0] copy_to;
   } req_type;

   typedef struct packed {
      logic [7:0] read_code;
      logic [7:0] read_color;
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic       scrolled;
   } rsp_type;

   // classified command handed from front to back
   typedef enum logic [2:0] {
      OP_NOP, OP_WRITE, OP_READ, OP_CLEAR, OP_COPY, OP_SCROLL
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [ADDR_W-1:0] addr;
      logic        put_code;
      logic        put_color;
      logic [7:0]  code;
      logic [7:0]  color;
      logic [SCR_W-1:0] src_scr;
      logic [SCR_W-1:0] dst_scr;
      logic [COL_W-1:0] cur_col;
      logic [ROW_W-1:0] cur_row;
      logic        scrolled;
      logic        scroll_after;
   } cmd_type;

   function automatic logic [ADDR_W-1:0] cell_addr(logic [SCR_W-1:0] s,
         logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
      logic [31:0] a;
      a = 32'(s) * 32'(SCREEN_CELLS) + 32'(y) * 32'(COLUMNS) + 32'(x);
      return a[ADDR_W-1:0];
   endfunction
endpackage

@@ hdl/tcse_front.sv @@
// Front end: accepts requests, tracks the cursor and classifies each request.
// Depends on tcse_pkg.
`timescale 1ns / 1ps
module tcse_front (
   input  logic             clock,
   input  logic             reset,
   input  tcse_pkg::req_type req,
   input  logic             req_take,
   input  logic [1:0]       scr_sel,
   output tcse_pkg::cmd_type cmd
);
   import tcse_pkg::*;
   logic [COL_W-1:0] cx_ff, cx_in;
   logic [ROW_W-1:0] cy_ff, cy_in;
   logic in_range;
   logic [COL_W:0] nx;

   assign in_range = (32'(req.pos_x) < COLUMNS) && (32'(req.pos_y) < ROWS);
   assign nx = {1'b0, cx_ff} + 1'b1;

   always_comb begin
      cmd = '0;
      cmd.op = OP_NOP;
      cmd.code = req.char_code;
      cmd.color = req.color_value;
      cmd.put_code = req.write_code;
      cmd.put_color = req.write_color;
      cmd.src_scr = req.copy_from;
      cmd.dst_scr = req.copy_to;
      cmd.addr = cell_addr(scr_sel, req.pos_x, req.pos_y);
      cx_in = cx_ff;
      cy_in = cy_ff;
      case (req_code_type'(req.req_type))
         REQ_PRINT: begin
            if (req.char_code != NEWLINE_CODE) begin
               cmd.op = OP_WRITE;
               cmd.put_code = 1'b1;
               cmd.addr = cell_addr(scr_sel, cx_ff, cy_ff);
               cx_in = nx[COL_W-1:0];
            end
            if (req.char_code == NEWLINE_CODE || 32'(nx) >= COLUMNS) begin
               cx_in = '0;
               if (32'(cy_ff) + 1 >= ROWS) begin
                  cmd.scrolled = 1'b1;
                  cmd.scroll_after = 1'b1;
                  if (req.char_code == NEWLINE_CODE) cmd.op = OP_SCROLL;
               end else begin
                  cy_in = cy_ff + 1'b1;
               end
            end
         end
         REQ_WRITE: if (in_range) cmd.op = OP_WRITE;
         REQ_READ:  if (in_range) cmd.op = OP_READ;
         REQ_CURSOR: begin
            cx_in = (32'(req.pos_x) < COLUMNS) ? req.pos_x : COL_W'(COLUMNS - 1);
            cy_in = (32'(req.pos_y) < ROWS) ? req.pos_y : ROW_W'(ROWS - 1);
         end
         REQ_CLEAR: begin
            cmd.op = OP_CLEAR;
            cmd.dst_scr = scr_sel;
            cx_in = '0;
            cy_in = '0;
         end
         REQ_COPY: if (32'(req.copy_from) < SCREENS && 32'(req.copy_to) < SCREENS
                       && req.copy_from != req.copy_to) cmd.op = OP_COPY;
         default: ;
      endcase
      if (cmd.op == OP_SCROLL || cmd.scroll_after) cmd.src_scr = scr_sel;
      cmd.cur_col = cx_in;
      cmd.cur_row = cy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
      end else if (req_take) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end
endmodule

@@ hdl/tcse_queue.sv @@
// Two-entry command queue between front and back end.
// Depends on tcse_pkg.
`timescale 1ns / 1ps
module tcse_queue (
   input  logic              clock,
   input  logic              reset,
   input  tcse_pkg::cmd_type wr_data,
   input  logic              wr_en,
   output logic              full,
   output tcse_pkg::cmd_type rd_data,
   output logic              empty,
   input  logic              rd_en
);
   import tcse_pkg::*;
   cmd_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= ~wp_ff;
         if (rd_en) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_en) - 2'(rd_en);
      end
   end
endmodule

@@ hdl/tcse_back.sv @@
// Back end: carries out cell operations and sweeps on the cell store.
// Depends on tcse_pkg.
`timescale 1ns / 1ps
module tcse_back (
   input  logic              clock,
   input  logic              reset,
   input  tcse_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_take,
   output tcse_pkg::rsp_type rsp,
   output logic              rsp_valid,
   input  logic              rsp_take
);
   import tcse_pkg::*;
   typedef enum logic [2:0] {S_IDLE, S_RMW, S_READ, S_SWEEP, S_WAIT, S_DONE} state_type;

   logic [15:0] store [STORE_CELLS];
   logic [15:0] rd_ff;
   state_type st_ff;
   cmd_type c_ff;
   logic [SCELL_W-1:0] i_ff;
   logic [ADDR_W-1:0] dst_ff, src_ff;
   logic scroll_ff;
   logic sweep_rd_ff;
   logic [ADDR_W-1:0] raddr, waddr;
   logic re, we;
   logic [15:0] wdata;
   rsp_type rsp_ff;
   logic rv_ff;

   assign cmd_take = cmd_valid && st_ff == S_IDLE && !rv_ff;
   assign rsp = rsp_ff;
   assign rsp_valid = rv_ff;

   // sweep: read source cell i, write the previous read (or a blank cell) to dst i-1
   always_comb begin
      re = 1'b0; we = 1'b0; raddr = c_ff.addr; waddr = c_ff.addr;
      wdata = rd_ff;
      if (c_ff.put_code) wdata[7:0] = c_ff.code;
      if (c_ff.put_color) wdata[15:8] = c_ff.color;
      case (st_ff)
         S_RMW: we = 1'b1;
         S_SWEEP: begin
            raddr = src_ff + ADDR_W'(i_ff);
            re = scroll_ff ? (32'(i_ff) < SCREEN_CELLS - COLUMNS)
                           : (c_ff.op == OP_COPY && 32'(i_ff) < SCREEN_CELLS);
            waddr = dst_ff + ADDR_W'(i_ff) - 1'b1;
            we = i_ff != '0;
            if (scroll_ff) begin
               wdata = sweep_rd_ff ? rd_ff : BLANK_CELL;
            end else begin
               wdata = (c_ff.op == OP_COPY) ? rd_ff : BLANK_CELL;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (re) rd_ff <= store[raddr];
      else if (st_ff == S_IDLE && cmd_take) rd_ff <= store[cmd.addr];
      if (we) store[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
         i_ff <= '0;
         scroll_ff <= 1'b0;
         sweep_rd_ff <= 1'b0;
      end else begin
         if (st_ff == S_DONE) rv_ff <= 1'b1;
         else if (rsp_take) rv_ff <= 1'b0;
         sweep_rd_ff <= re;
         unique case (st_ff)
            S_IDLE: if (cmd_take) begin
               c_ff <= cmd;
               i_ff <= '0;
               scroll_ff <= (cmd.op == OP_SCROLL);
               rsp_ff <= '{read_code: 8'd0, read_color: 8'd0, cursor_col: cmd.cur_col,
                           cursor_row: cmd.cur_row, scrolled: cmd.scrolled};
               unique case (cmd.op)
                  OP_WRITE: st_ff <= S_RMW;
                  OP_READ: st_ff <= S_READ;
                  OP_CLEAR: begin
                     st_ff <= S_SWEEP;
                     dst_ff <= cell_addr(cmd.dst_scr, '0, '0);
                     src_ff <= cell_addr(cmd.dst_scr, '0, '0);
                  end
                  OP_COPY: begin
                     st_ff <= S_SWEEP;
                     dst_ff <= cell_addr(cmd.dst_scr, '0, '0);
                     src_ff <= cell_addr(cmd.src_scr, '0, '0);
                  end
                  OP_SCROLL: begin
                     st_ff <= S_SWEEP;
                     dst_ff <= cell_addr(cmd.src_scr, '0, '0);
                     src_ff <= cell_addr(cmd.src_scr, '0, '0) + ADDR_W'(COLUMNS);
                  end
                  default: st_ff <= S_DONE;
               endcase
            end
            S_RMW: begin
               if (c_ff.scroll_after) begin
                  st_ff <= S_SWEEP;
                  scroll_ff <= 1'b1;
                  i_ff <= '0;
                  dst_ff <= cell_addr(c_ff.src_scr, '0, '0);
                  src_ff <= cell_addr(c_ff.src_scr, '0, '0) + ADDR_W'(COLUMNS);
               end else st_ff <= S_DONE;
            end
            S_READ: begin
               rsp_ff.read_code <= rd_ff[7:0];
               rsp_ff.read_color <= rd_ff[15:8];
               st_ff <= S_DONE;
            end
            S_SWEEP: begin
               if (32'(i_ff) == SCREEN_CELLS) st_ff <= S_DONE;
               else i_ff <= i_ff + 1'b1;
            end
            S_WAIT: st_ff <= S_DONE;
            S_DONE: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ hdl/text_console_scroll_engine.sv @@
// Top level of the text console scroll engine: front end, command queue, back end.
// Depends on tcse_pkg, tcse_front, tcse_queue, tcse_back.
`timescale 1ns / 1ps
// A console over four 80x25 screens of 16-bit cells. Requests enter a queue; the cursor
// is tracked at once in the front end, so results report the cursor after the request.
// Write, read and non-scrolling print requests read or update a single cell; set-cursor,
// a newline that does not scroll and unused codes touch no cell. Clear, copy and any
// print that scrolls walk one screen cell a cycle through the read and write ports of
// the cell store. One request is carried out at a time, and the back end starts the
// next one only once the previous result has been popped; a two-deep command queue
// lets requests be taken while the back end works. The store holds undefined data
// until written or cleared.
module text_console_scroll_engine (
   input  logic              clock,
   input  logic              reset,
   input  tcse_pkg::req_type req_data,
   input  logic              push,
   output logic              full,
   output tcse_pkg::rsp_type rsp_data,
   output logic              empty,
   input  logic              pop,
   input  logic [1:0]        csr_data,
   input  logic              csr_valid,
   output logic              csr_ready
);
   import tcse_pkg::*;
   logic [SCR_W-1:0] sel_ff;
   cmd_type f_cmd, q_cmd;
   logic q_empty, c_take, r_valid;
   logic take;

   assign take = push && !full;
   assign csr_ready = 1'b1;
   assign empty = !r_valid;

   always_ff @(posedge clock) begin
      if (reset) sel_ff <= '0;
      else if (csr_valid && csr_ready && 32'(csr_data) < SCREENS) sel_ff <= csr_data;
   end

   tcse_front u_front (.clock, .reset, .req(req_data), .req_take(take),
      .scr_sel(sel_ff), .cmd(f_cmd));
   tcse_queue u_queue (.clock, .reset, .wr_data(f_cmd), .wr_en(take), .full,
      .rd_data(q_cmd), .empty(q_empty), .rd_en(c_take));
   tcse_back u_back (.clock, .reset, .cmd(q_cmd), .cmd_valid(!q_empty),
      .cmd_take(c_take), .rsp(rsp_data), .rsp_valid(r_valid), .rsp_take(pop));
endmodule

@@ hdl/tcse_checker.sv @@
// Port-level checks for the text console scroll engine, bound to the top level.
// Depends on tcse_pkg.
`timescale 1ns / 1ps
module tcse_checker (
   input logic clock,
   input logic reset,
   input tcse_pkg::rsp_type rsp_data,
   input logic empty,
   input logic pop,
   input logic full
);
   import tcse_pkg::*;
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data)) else $error("result dropped");
   a_col: assert property (@(posedge clock) disable iff (reset)
      !empty |-> 32'(rsp_data.cursor_col) < COLUMNS) else $error("column range");
   a_row: assert property (@(posedge clock) disable iff (reset)
      !empty |-> 32'(rsp_data.cursor_row) < ROWS) else $error("row range");
   a_rst: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("reset state");
endmodule

bind text_console_scroll_engine tcse_checker u_chk (.clock, .reset, .rsp_data, .empty,
   .pop, .full);
